### design/tce_pkg.sv
// Shared opcodes, action codes and ALU result type for the toy 16-bit execute core.
`default_nettype none

package tce_pkg;

    // Instruction opcodes; every code above OP_BRA halts the core
    typedef enum logic [3:0] {
        OP_LDI = 4'd0,
        OP_LD  = 4'd1,
        OP_ST  = 4'd2,
        OP_ADD = 4'd3,
        OP_SUB = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_SHL = 4'd8,
        OP_SHR = 4'd9,
        OP_BNZ = 4'd10,
        OP_BNN = 4'd11,
        OP_BRA = 4'd12
    } t_opcode;

    // Item kinds
    localparam logic ACT_EXEC    = 1'b0;
    localparam logic ACT_PRELOAD = 1'b1;

    // Register write request from the ALU
    typedef struct packed {
        logic        wr;
        logic        set_neg;
        logic [15:0] value;
    } t_alu_out;

endpackage

`default_nettype wire

### design/tce_alu.sv
// Register-result datapath of the execute core: immediate, load data and ALU operations.
`default_nettype none

module tce_alu (
    input  wire logic [3:0]  i_op,
    input  wire logic [7:0]  i_imm8,
    input  wire logic [15:0] i_va,
    input  wire logic [15:0] i_vb,
    input  wire logic [15:0] i_load_data,
    output tce_pkg::t_alu_out o_res
);

    // Select the result and whether it writes a register
    always_comb begin
        o_res = '0;
        case (tce_pkg::t_opcode'(i_op))
            tce_pkg::OP_LDI: begin
                o_res.wr    = 1'b1;
                o_res.value = {8'h00, i_imm8};
            end
            tce_pkg::OP_LD: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = i_load_data;
            end
            tce_pkg::OP_ADD: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = i_va + i_vb;
            end
            tce_pkg::OP_SUB: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = i_va - i_vb;
            end
            tce_pkg::OP_AND: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = i_va & i_vb;
            end
            tce_pkg::OP_OR: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = i_va | i_vb;
            end
            tce_pkg::OP_XOR: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = i_va ^ i_vb;
            end
            tce_pkg::OP_SHL: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = (i_vb[15:4] != 12'd0) ? 16'd0 : (i_va << i_vb[3:0]);
            end
            tce_pkg::OP_SHR: begin
                o_res.wr      = 1'b1;
                o_res.set_neg = 1'b1;
                o_res.value   = (i_vb[15:4] != 12'd0) ? 16'd0 : (i_va >> i_vb[3:0]);
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/toy_16bit_cpu_execute_core.sv
// Top level of the toy 16-bit execute core: register file, data store and result stage.
//
// The core takes one item per clock when the result side keeps up. An item's
// transfer loads the stage one registers and issues the register file and data
// store reads; stage one then executes it, and as it advances it writes back
// and loads the result register. The registered reads of the memories are
// covered by write-to-read forwarding, so dependent instructions still go back
// to back. After reset the core clears the data store, one word per cycle, and
// holds o_ready low while it does so.
`default_nettype none

module toy_16bit_cpu_execute_core #(
    parameter int PROGRAM_DEPTH = 1024,
    parameter int DATA_DEPTH    = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [15:0] i_instruction,
    input  wire logic [9:0]  i_preload_address,
    input  wire logic [15:0] i_preload_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [9:0]       o_next_ip,
    output logic             o_halted,
    output logic             o_reg_written,
    output logic [3:0]       o_reg_index,
    output logic [15:0]      o_reg_value,
    output logic             o_mem_written,
    output logic [9:0]       o_mem_address,
    output logic [15:0]      o_mem_value,
    output logic             o_zero_out,
    output logic             o_negative_out
);

    localparam int PW   = $clog2(PROGRAM_DEPTH);
    localparam int DW   = $clog2(DATA_DEPTH);
    localparam int IPX  = (PW > 10) ? PW : 10;
    localparam int AX   = (DW > 10) ? DW : 10;
    localparam int RSH  = 24;
    localparam int RECIP = ((1 << RSH) + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH;

    // Pipeline control
    logic accept;
    logic s1_adv;

    // Accept-side decode
    logic [3:0]    in_op;
    logic [3:0]    in_ra0;
    logic [3:0]    in_ra1;
    logic [DW-1:0] in_dm_raddr;
    logic [12:0]   pl_mod;
    logic [DW-1:0] in_pl_addr;
    logic [35:0]   q_prod;

    // Stage one registers
    logic          r_s1_valid;
    logic          r_s1_action;
    logic [15:0]   r_s1_instr;
    logic [DW-1:0] r_s1_pl_addr;
    logic [15:0]   r_s1_pl_data;
    logic [11:0]   r_s1_off_q;

    // Register file and its forwarding
    logic [15:0] r_rf [16];
    logic [15:0] r_rf_valid;
    logic [15:0] r_rf_q0;
    logic [15:0] r_rf_q1;
    logic        r_fw0;
    logic        r_fw1;
    logic [15:0] r_fw_data;
    logic        rf_we;
    logic [3:0]  rf_waddr;

    // Data store, its forwarding and clearing pass
    logic [15:0]   r_dm [DATA_DEPTH];
    logic [15:0]   r_dm_q;
    logic          r_fwm;
    logic [15:0]   r_fwm_data;
    logic          r_clear;
    logic [DW-1:0] r_clr_addr;
    logic          dm_we;
    logic [DW-1:0] dm_waddr;
    logic [15:0]   dm_wdata;

    // Architectural state
    logic [PW-1:0] r_ip;
    logic          r_zero;
    logic          r_neg;
    logic          r_stopped;

    // Stage one execute
    logic [3:0]        s1_op;
    logic [3:0]        s1_ra0;
    logic [15:0]       va;
    logic [15:0]       vb;
    logic [15:0]       load_data;
    tce_pkg::t_alu_out alu_res;
    logic              exec;
    logic              preload;
    logic              rw;
    logic              mw;
    logic [DW-1:0]     m_addr;
    logic [15:0]       m_val;
    logic              is_branch;
    logic              taken;
    logic              halt;
    logic [23:0]       qp_prod;
    logic [12:0]       off_rem;
    logic [PW-1:0]     off_mod;
    logic [PW-1:0]     addend;
    logic [PW:0]       ip_sum;
    logic [PW-1:0]     n_ip;
    logic              n_zero;
    logic              n_neg;
    logic              n_stopped;
    logic [IPX-1:0]    n_ip_x;
    logic [AX-1:0]     m_addr_x;

    // Result register
    logic        r_o_valid;
    logic [9:0]  r_o_next_ip;
    logic        r_o_halted;
    logic        r_o_reg_written;
    logic [3:0]  r_o_reg_index;
    logic [15:0] r_o_reg_value;
    logic        r_o_mem_written;
    logic [9:0]  r_o_mem_address;
    logic [15:0] r_o_mem_value;
    logic        r_o_zero;
    logic        r_o_neg;

    // Handshake: stage one advances when the result register is free or drains
    assign s1_adv  = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_clear && (!r_s1_valid || s1_adv);
    assign accept  = i_valid && o_ready;

    // Decode read addresses at transfer; a store reads its data register on port 0
    assign in_op       = i_instruction[15:12];
    assign in_ra0      = (tce_pkg::t_opcode'(in_op) == tce_pkg::OP_ST) ?
                         i_instruction[11:8] : i_instruction[7:4];
    assign in_ra1      = i_instruction[3:0];
    assign in_dm_raddr = DW'(i_instruction[7:0]);

    // Fold the preload address into the data store depth
    always_comb begin
        pl_mod = 13'(i_preload_address);
        for (int k = 0; k < 3; k++) begin
            if (pl_mod >= 13'(DATA_DEPTH)) begin
                pl_mod = pl_mod - 13'(DATA_DEPTH);
            end
        end
    end
    assign in_pl_addr = DW'(pl_mod);

    // Estimate the branch offset quotient by the program depth
    assign q_prod = 36'(i_instruction[11:0]) * 36'(RECIP);

    // Stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action  <= i_action;
            r_s1_instr   <= i_instruction;
            r_s1_pl_addr <= in_pl_addr;
            r_s1_pl_data <= i_preload_data;
            r_s1_off_q   <= q_prod[RSH+11:RSH];
        end
    end

    // Register file: write back from stage one, read at transfer
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= alu_res.value;
        end
        if (accept) begin
            r_rf_q0 <= r_rf[in_ra0];
            r_rf_q1 <= r_rf[in_ra1];
        end
    end

    // Mark written registers; an unwritten register reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
        end else if (rf_we) begin
            r_rf_valid[rf_waddr] <= 1'b1;
        end
    end

    // Forward a write that lands at the same edge as the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw0 <= 1'b0;
            r_fw1 <= 1'b0;
            r_fwm <= 1'b0;
        end else if (accept) begin
            r_fw0 <= rf_we && (rf_waddr == in_ra0);
            r_fw1 <= rf_we && (rf_waddr == in_ra1);
            r_fwm <= dm_we && (dm_waddr == in_dm_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fw_data  <= alu_res.value;
            r_fwm_data <= dm_wdata;
        end
    end

    // Clearing pass over the data store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear    <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == DW'(DATA_DEPTH - 1)) begin
                r_clear <= 1'b0;
            end
        end
    end

    assign dm_we    = r_clear || (s1_adv && mw);
    assign dm_waddr = r_clear ? r_clr_addr : m_addr;
    assign dm_wdata = r_clear ? 16'd0 : m_val;

    // Data store: write from clear or stage one, read at transfer
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            r_dm[dm_waddr] <= dm_wdata;
        end
        if (accept) begin
            r_dm_q <= r_dm[in_dm_raddr];
        end
    end

    // Operand selection with forwarding
    assign s1_op     = r_s1_instr[15:12];
    assign s1_ra0    = (tce_pkg::t_opcode'(s1_op) == tce_pkg::OP_ST) ?
                       r_s1_instr[11:8] : r_s1_instr[7:4];
    assign va        = r_fw0 ? r_fw_data :
                       (r_rf_valid[s1_ra0] ? r_rf_q0 : 16'd0);
    assign vb        = r_fw1 ? r_fw_data :
                       (r_rf_valid[r_s1_instr[3:0]] ? r_rf_q1 : 16'd0);
    assign load_data = r_fwm ? r_fwm_data : r_dm_q;

    tce_alu u_alu (
        .i_op        (s1_op),
        .i_imm8      (r_s1_instr[7:0]),
        .i_va        (va),
        .i_vb        (vb),
        .i_load_data (load_data),
        .o_res       (alu_res)
    );

    // Item kind and writes
    assign preload  = (r_s1_action == tce_pkg::ACT_PRELOAD);
    assign exec     = (r_s1_action == tce_pkg::ACT_EXEC) && !r_stopped;
    assign rw       = exec && alu_res.wr;
    assign mw       = preload || (exec && (tce_pkg::t_opcode'(s1_op) == tce_pkg::OP_ST));
    assign m_addr   = preload ? r_s1_pl_addr : DW'(r_s1_instr[7:0]);
    assign m_val    = preload ? r_s1_pl_data : va;
    assign rf_we    = s1_adv && rw;
    assign rf_waddr = r_s1_instr[11:8];

    // Branch decision and halt
    always_comb begin
        is_branch = 1'b0;
        taken     = 1'b0;
        halt      = 1'b0;
        case (tce_pkg::t_opcode'(s1_op))
            tce_pkg::OP_LDI, tce_pkg::OP_LD, tce_pkg::OP_ST, tce_pkg::OP_ADD,
            tce_pkg::OP_SUB, tce_pkg::OP_AND, tce_pkg::OP_OR, tce_pkg::OP_XOR,
            tce_pkg::OP_SHL, tce_pkg::OP_SHR: begin
                is_branch = 1'b0;
            end
            tce_pkg::OP_BNZ: begin
                is_branch = 1'b1;
                taken     = !r_zero;
            end
            tce_pkg::OP_BNN: begin
                is_branch = 1'b1;
                taken     = !r_neg;
            end
            tce_pkg::OP_BRA: begin
                is_branch = 1'b1;
                taken     = 1'b1;
            end
            default: begin
                halt = 1'b1;
            end
        endcase
    end

    // Offset remainder by the program depth, then wrap the pointer once
    assign qp_prod = 24'(r_s1_off_q) * 24'(PROGRAM_DEPTH);
    always_comb begin
        off_rem = 13'(r_s1_instr[11:0]) - qp_prod[12:0];
        if (off_rem >= 13'(PROGRAM_DEPTH)) begin
            off_rem = off_rem - 13'(PROGRAM_DEPTH);
        end
    end
    assign off_mod = PW'(off_rem);
    assign addend  = (is_branch && taken) ? off_mod : PW'(1);

    always_comb begin
        ip_sum = {1'b0, r_ip} + {1'b0, addend};
        if (ip_sum >= (PW + 1)'(PROGRAM_DEPTH)) begin
            ip_sum = ip_sum - (PW + 1)'(PROGRAM_DEPTH);
        end
    end

    // Next architectural state
    assign n_ip      = (exec && !halt) ? ip_sum[PW-1:0] : r_ip;
    assign n_zero    = rw ? (alu_res.value == 16'd0) : r_zero;
    assign n_neg     = (rw && alu_res.set_neg) ? alu_res.value[15] : r_neg;
    assign n_stopped = r_stopped || (exec && halt);
    assign n_ip_x    = IPX'(n_ip);
    assign m_addr_x  = AX'(m_addr);

    // Commit state as stage one advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip      <= '0;
            r_zero    <= 1'b0;
            r_neg     <= 1'b0;
            r_stopped <= 1'b0;
        end else if (s1_adv) begin
            r_ip      <= n_ip;
            r_zero    <= n_zero;
            r_neg     <= n_neg;
            r_stopped <= n_stopped;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_next_ip     <= n_ip_x[9:0];
            r_o_halted      <= n_stopped;
            r_o_reg_written <= rw;
            r_o_reg_index   <= rw ? rf_waddr : 4'd0;
            r_o_reg_value   <= rw ? alu_res.value : 16'd0;
            r_o_mem_written <= mw;
            r_o_mem_address <= mw ? m_addr_x[9:0] : 10'd0;
            r_o_mem_value   <= mw ? m_val : 16'd0;
            r_o_zero        <= n_zero;
            r_o_neg         <= n_neg;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_next_ip      = r_o_next_ip;
    assign o_halted       = r_o_halted;
    assign o_reg_written  = r_o_reg_written;
    assign o_reg_index    = r_o_reg_index;
    assign o_reg_value    = r_o_reg_value;
    assign o_mem_written  = r_o_mem_written;
    assign o_mem_address  = r_o_mem_address;
    assign o_mem_value    = r_o_mem_value;
    assign o_zero_out     = r_o_zero;
    assign o_negative_out = r_o_neg;

endmodule

`default_nettype wire

### sim/toy_16bit_cpu_execute_core_tb.sv
// Self-checking testbench for the toy 16-bit execute core: directed, random and halt traffic.

module toy_16bit_cpu_execute_core_tb;

    localparam int PROGRAM_DEPTH = 1024;
    localparam int DATA_DEPTH    = 1024;
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RUN_LIMIT     = 3_000_000;
    localparam int ITEMS_PER_MIX = 175;

    // Opcodes past the last branch all stop the core
    localparam logic [3:0] HALT_OP_LO = 4'(tce_pkg::OP_BRA) + 4'd1;
    localparam logic [3:0] HALT_OP_HI = 4'hF;

    typedef struct packed {
        logic [9:0]  next_ip;
        logic        halted;
        logic        reg_written;
        logic [3:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [9:0]  mem_address;
        logic [15:0] mem_value;
        logic        zero_out;
        logic        negative_out;
    } t_outcome;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        i_action          = tce_pkg::ACT_EXEC;
    logic [15:0] i_instruction     = '0;
    logic [9:0]  i_preload_address = '0;
    logic [15:0] i_preload_data    = '0;
    logic        i_ready           = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [9:0]  o_next_ip;
    logic        o_halted;
    logic        o_reg_written;
    logic [3:0]  o_reg_index;
    logic [15:0] o_reg_value;
    logic        o_mem_written;
    logic [9:0]  o_mem_address;
    logic [15:0] o_mem_value;
    logic        o_zero_out;
    logic        o_negative_out;

    // Architectural state mirrored by the predictor
    logic [15:0] regs [16]               = '{default: '0};
    logic [15:0] data_words [DATA_DEPTH] = '{default: '0};
    int unsigned prog_ip      = 0;
    logic        pred_zero    = 1'b0;
    logic        neg_flag     = 1'b0;
    logic        core_stopped = 1'b0;

    t_outcome pending_outcomes [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    bit hold_request    = 1'b0;
    int hold_left       = 0;
    int items_sent      = 0;
    int preloads_sent   = 0;
    int ignored_sent    = 0;
    int results_checked = 0;
    int failures        = 0;

    toy_16bit_cpu_execute_core #(
        .PROGRAM_DEPTH(PROGRAM_DEPTH),
        .DATA_DEPTH   (DATA_DEPTH)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_instruction    (i_instruction),
        .i_preload_address(i_preload_address),
        .i_preload_data   (i_preload_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_next_ip        (o_next_ip),
        .o_halted         (o_halted),
        .o_reg_written    (o_reg_written),
        .o_reg_index      (o_reg_index),
        .o_reg_value      (o_reg_value),
        .o_mem_written    (o_mem_written),
        .o_mem_address    (o_mem_address),
        .o_mem_value      (o_mem_value),
        .o_zero_out       (o_zero_out),
        .o_negative_out   (o_negative_out)
    );

    always #5 i_clk = ~i_clk;

    // Run one item through the core state and queue the result it must produce
    task automatic predict_outcome(input logic act, input logic [15:0] instr,
                                   input logic [9:0] paddr, input logic [15:0] pdata);
        t_outcome    exp_out;
        logic [3:0]  op;
        logic [3:0]  rd;
        int unsigned va;
        int unsigned vb;
        int unsigned res;
        int unsigned off;
        int unsigned addr;
        exp_out = '0;
        res     = 0;
        if (act == tce_pkg::ACT_PRELOAD) begin
            addr = paddr % DATA_DEPTH;
            data_words[addr] = pdata;
            exp_out.mem_written = 1'b1;
            exp_out.mem_address = addr[9:0];
            exp_out.mem_value   = pdata;
        end else if (!core_stopped) begin
            op  = instr[15:12];
            rd  = instr[11:8];
            va  = regs[instr[7:4]];
            vb  = regs[instr[3:0]];
            off = instr[11:0];
            exp_out.reg_written = (op <= tce_pkg::OP_SHR) && (op != tce_pkg::OP_ST);
            case (op)
                tce_pkg::OP_LDI: res = instr[7:0];
                tce_pkg::OP_LD:  res = data_words[instr[7:0] % DATA_DEPTH];
                tce_pkg::OP_ST: begin
                    addr = instr[7:0] % DATA_DEPTH;
                    data_words[addr] = regs[rd];
                    exp_out.mem_written = 1'b1;
                    exp_out.mem_address = addr[9:0];
                    exp_out.mem_value   = regs[rd];
                end
                tce_pkg::OP_ADD: res = (va + vb) & 16'hFFFF;
                tce_pkg::OP_SUB: res = (va - vb) & 16'hFFFF;
                tce_pkg::OP_AND: res = va & vb;
                tce_pkg::OP_OR:  res = va | vb;
                tce_pkg::OP_XOR: res = va ^ vb;
                tce_pkg::OP_SHL: res = (vb >= 16) ? 0 : ((va << vb) & 16'hFFFF);
                tce_pkg::OP_SHR: res = (vb >= 16) ? 0 : (va >> vb);
                tce_pkg::OP_BNZ:
                    prog_ip = (prog_ip + (pred_zero ? 1 : off)) % PROGRAM_DEPTH;
                tce_pkg::OP_BNN:
                    prog_ip = (prog_ip + (neg_flag ? 1 : off)) % PROGRAM_DEPTH;
                tce_pkg::OP_BRA: prog_ip = (prog_ip + off) % PROGRAM_DEPTH;
                default: core_stopped = 1'b1;
            endcase
            if (exp_out.reg_written) begin
                regs[rd]  = res[15:0];
                pred_zero = (res[15:0] == 16'd0);
                if (op != tce_pkg::OP_LDI) begin
                    neg_flag = res[15];
                end
                exp_out.reg_index = rd;
                exp_out.reg_value = res[15:0];
            end
            if (op <= tce_pkg::OP_SHR) begin
                prog_ip = (prog_ip + 1) % PROGRAM_DEPTH;
            end
        end
        exp_out.next_ip      = prog_ip[9:0];
        exp_out.halted       = core_stopped;
        exp_out.zero_out     = pred_zero;
        exp_out.negative_out = neg_flag;
        pending_outcomes.push_back(exp_out);
    endtask

    // Offer one item after a random idle gap and hold it until the transfer
    task automatic send_item(input logic act, input logic [15:0] instr,
                             input logic [9:0] paddr, input logic [15:0] pdata);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_action          <= act;
        i_instruction     <= instr;
        i_preload_address <= paddr;
        i_preload_data    <= pdata;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (act == tce_pkg::ACT_PRELOAD) begin
            preloads_sent++;
        end else if (core_stopped) begin
            ignored_sent++;
        end
        predict_outcome(act, instr, paddr, pdata);
    endtask

    task automatic send_exec(input logic [3:0] op, input logic [3:0] rd,
                             input logic [3:0] ra, input logic [3:0] rb);
        send_item(tce_pkg::ACT_EXEC, {op, rd, ra, rb}, 10'($urandom), 16'($urandom));
    endtask

    task automatic send_preload(input logic [9:0] addr, input logic [15:0] data);
        send_item(tce_pkg::ACT_PRELOAD, 16'($urandom), addr, data);
    endtask

    // Drop valid, then switch the idling mix between clock edges
    task automatic enter_phase(input int idle_pct, input int stall_pct, input bit hold);
        i_valid <= 1'b0;
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold) begin
            hold_request = 1'b1;
        end
        @(posedge i_clk);
    endtask

    // Favor corner words and small values usable as shift amounts
    function automatic logic [15:0] random_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'($urandom_range(20));
            default: return 16'($urandom);
        endcase
    endfunction

    // Any opcode that keeps the core running, with random operand fields
    function automatic logic [15:0] random_instruction();
        int          pick;
        logic [3:0]  op;
        logic [11:0] fields;
        pick   = $urandom_range(99);
        fields = 12'($urandom);
        if (pick < 18) begin
            op = tce_pkg::OP_LDI;
            if ($urandom_range(1) == 0) begin
                fields[7:0] = 8'($urandom_range(20));
            end
        end else if (pick < 28) begin
            op = tce_pkg::OP_LD;
        end else if (pick < 38) begin
            op = tce_pkg::OP_ST;
        end else if (pick < 85) begin
            op = 4'($urandom_range(tce_pkg::OP_SHR, tce_pkg::OP_ADD));
        end else begin
            op = 4'($urandom_range(tce_pkg::OP_BRA, tce_pkg::OP_BNZ));
        end
        return {op, fields};
    endfunction

    task automatic test_directed_ops();
        enter_phase(30, 30, 1'b0);
        // Store reads as zero after reset
        send_exec(tce_pkg::OP_LD, 4'd1, 4'hA, 4'hB);
        send_preload(10'h3FF, 16'hFFFF);
        send_preload(10'h0AB, 16'h8001);
        send_exec(tce_pkg::OP_LD, 4'd3, 4'hA, 4'hB);
        // Load immediate leaves the negative flag alone
        send_exec(tce_pkg::OP_LDI, 4'd1, 4'hF, 4'hF);
        send_exec(tce_pkg::OP_LDI, 4'd2, 4'h0, 4'h0);
        send_exec(tce_pkg::OP_ST, 4'd3, 4'hF, 4'hF);
        send_exec(tce_pkg::OP_LD, 4'd4, 4'hF, 4'hF);
        send_exec(tce_pkg::OP_ST, 4'd2, 4'h0, 4'h0);
        send_exec(tce_pkg::OP_ADD, 4'd5, 4'd3, 4'd3);
        send_exec(tce_pkg::OP_SUB, 4'd6, 4'd2, 4'd1);
        send_exec(tce_pkg::OP_AND, 4'd7, 4'd3, 4'd1);
        send_exec(tce_pkg::OP_OR, 4'd8, 4'd3, 4'd1);
        send_exec(tce_pkg::OP_XOR, 4'd9, 4'd3, 4'd3);
        // Shifts by 15, by 16 and by a large amount
        send_exec(tce_pkg::OP_LDI, 4'd10, 4'h0, 4'hF);
        send_exec(tce_pkg::OP_SHL, 4'd11, 4'd3, 4'd10);
        send_exec(tce_pkg::OP_SHR, 4'd12, 4'd3, 4'd10);
        send_exec(tce_pkg::OP_LDI, 4'd13, 4'h1, 4'h0);
        send_exec(tce_pkg::OP_SHL, 4'd14, 4'd3, 4'd13);
        send_exec(tce_pkg::OP_SHR, 4'd14, 4'd1, 4'd13);
        send_exec(tce_pkg::OP_SHL, 4'd15, 4'd1, 4'd1);
        // Branches taken and not taken, with wrap of the pointer
        send_exec(tce_pkg::OP_BNZ, 4'h0, 4'h0, 4'h5);
        send_exec(tce_pkg::OP_LDI, 4'd0, 4'h0, 4'h1);
        send_exec(tce_pkg::OP_BNZ, 4'h0, 4'h0, 4'h5);
        send_exec(tce_pkg::OP_BNN, 4'hF, 4'hF, 4'hF);
        send_exec(tce_pkg::OP_SUB, 4'd0, 4'd2, 4'd1);
        send_exec(tce_pkg::OP_BNN, 4'h1, 4'h2, 4'h3);
        send_exec(tce_pkg::OP_BRA, 4'h8, 4'h0, 4'h0);
        send_exec(tce_pkg::OP_BRA, 4'h0, 4'h0, 4'h0);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct, input bit hold);
        logic [9:0] addr;
        enter_phase(idle_pct, stall_pct, hold);
        repeat (count) begin
            if ($urandom_range(99) < 15) begin
                // Mostly addresses that loads and stores can reach
                addr = ($urandom_range(9) < 7) ? 10'($urandom_range(255))
                                               : 10'($urandom_range(DATA_DEPTH - 1));
                send_preload(addr, random_word());
            end else begin
                send_item(tce_pkg::ACT_EXEC, random_instruction(), 10'($urandom),
                          16'($urandom));
            end
        end
    endtask

    task automatic test_halt();
        logic [3:0] op;
        enter_phase(25, 25, 1'b0);
        send_exec(tce_pkg::OP_LDI, 4'd1, 4'h4, 4'h2);
        op = 4'($urandom_range(HALT_OP_HI, HALT_OP_LO));
        send_item(tce_pkg::ACT_EXEC, {op, 12'($urandom)}, 10'($urandom), 16'($urandom));
        // Execute items are now ignored, preloads still land
        send_exec(tce_pkg::OP_LDI, 4'd2, 4'h0, 4'h5);
        send_exec(tce_pkg::OP_BRA, 4'h1, 4'h0, 4'h0);
        send_exec(HALT_OP_LO, 4'h0, 4'h0, 4'h0);
        send_item(tce_pkg::ACT_EXEC, 16'hFFFF, 10'h3FF, 16'hFFFF);
        send_exec(tce_pkg::OP_ST, 4'd1, 4'h1, 4'h0);
        send_preload(10'h010, 16'h1234);
        send_preload(10'h3FF, 16'h0000);
        repeat (10) begin
            if ($urandom_range(3) == 0) begin
                send_preload(10'($urandom), 16'($urandom));
            end else begin
                send_item(tce_pkg::ACT_EXEC, 16'($urandom), 10'($urandom), 16'($urandom));
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result transfer with nothing expected, next_ip %0h",
                         $time, o_next_ip);
                failures++;
            end else begin
                want = pending_outcomes.pop_front();
                results_checked++;
                check_field("next_ip", want.next_ip, o_next_ip);
                check_field("halted", want.halted, o_halted);
                check_field("reg_written", want.reg_written, o_reg_written);
                check_field("reg_index", want.reg_index, o_reg_index);
                check_field("reg_value", want.reg_value, o_reg_value);
                check_field("mem_written", want.mem_written, o_mem_written);
                check_field("mem_address", want.mem_address, o_mem_address);
                check_field("mem_value", want.mem_value, o_mem_value);
                check_field("zero_out", want.zero_out, o_zero_out);
                check_field("negative_out", want.negative_out, o_negative_out);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_random_traffic(ITEMS_PER_MIX, 0, 0, 1'b1);
        test_random_traffic(ITEMS_PER_MIX, 57, 0, 1'b0);
        test_random_traffic(ITEMS_PER_MIX, 0, 57, 1'b0);
        test_random_traffic(ITEMS_PER_MIX, 25, 25, 1'b0);
        test_halt();
        // Let the last results drain out
        enter_phase(0, 0, 1'b0);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d transfers (%0d preloads, %0d ignored after halt), %0d results",
                 items_sent, preloads_sent, ignored_sent, results_checked);
        $display("mixes: back to back with a long output hold-off, input gaps, output stalls, both");
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(RUN_LIMIT);
        $display("%0t: run limit reached with %0d results outstanding",
                 $time, pending_outcomes.size());
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
design/tce_pkg.sv
design/tce_alu.sv
design/toy_16bit_cpu_execute_core.sv
sim/toy_16bit_cpu_execute_core_tb.sv
